// File: hw/rtl/rk4u_pkg.sv
// ----------------------------------------------------------------------------
// rk4u_pkg
// Shared widths, stage codes, register indexes, item types and saturation
// for the Runge-Kutta stage update of a second-order system.
// ----------------------------------------------------------------------------
`default_nettype none

package rk4u_pkg;

  localparam int NUM_VARS = 1024;
  localparam int IDX_W    = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int EXT_W    = 17;

  localparam int VI_W = 10;
  localparam int VW   = 48;
  localparam int QW   = 52;
  localparam int FW   = 32;

  localparam int S_TDATA_W = 160;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 96;
  localparam int M_TUSER_W = 1;

  localparam int Q_DEPTH = 4;
  localparam int QP_W    = $clog2(Q_DEPTH);

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] FUNC_FIRST  = 2'd0;
  localparam logic [1:0] FUNC_SECOND = 2'd1;
  localparam logic [1:0] FUNC_THIRD  = 2'd2;
  localparam logic [1:0] FUNC_FINAL  = 2'd3;

  localparam logic [1:0] REG_STEP_FULL    = 2'd0;
  localparam logic [1:0] REG_STEP_HALF    = 2'd1;
  localparam logic [1:0] REG_STEP_QUARTER = 2'd2;

  localparam logic [FW-1:0] SIXTH_Q32 = 32'h2AAA_AAAB;

  typedef struct packed {
    logic start;
    logic two;
    logic three;
  } wr_t;

  typedef struct packed {
    logic [1:0]       func;
    logic             ok;
    wr_t              we;
    logic [IDX_W-1:0] addr;
    logic [VW-1:0]    x;
    logic [VW-1:0]    v;
    logic [VW-1:0]    a;
  } item_t;

  typedef struct packed {
    logic [FW-1:0] full;
    logic [FW-1:0] half;
    logic [FW-1:0] quarter;
  } cfg_t;

  typedef struct packed {
    logic          clip;
    logic [VW-1:0] value;
  } sat_t;

  function automatic sat_t sat48(input logic signed [QW-1:0] val);
    sat_t          r;
    logic [QW-VW:0] top;
    top = val[QW-1:VW-1];
    if (top == '0 || top == '1) begin
      r.clip  = 1'b0;
      r.value = val[VW-1:0];
    end else begin
      r.clip  = 1'b1;
      r.value = val[QW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rk4u_front.sv
// ----------------------------------------------------------------------------
// rk4u_front
// Input stage: accept words, unpack fields, range-check the index and
// decode which stores the stage writes, then hand items to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4u_front import rk4u_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  input  logic                 full_i,
  output logic                 push_o,
  output item_t                item_o
);

  logic             vld_q, vld_d;
  item_t            item_q, item_d;
  logic             accept;
  logic [EXT_W-1:0] idx_ext;
  logic             ok;
  logic [1:0]       func;

  assign s_axis_tready = !vld_q || !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_o        = vld_q && !full_i;
  assign item_o        = item_q;

  assign func    = s_axis_tuser;
  assign idx_ext = EXT_W'(s_axis_tdata[VI_W-1:0]);
  assign ok      = idx_ext < EXT_W'(NUM_VARS);

  always_comb begin
    item_d.func     = func;
    item_d.ok       = ok;
    item_d.we.start = ok && (func == FUNC_FIRST);
    item_d.we.two   = ok && (func == FUNC_SECOND);
    item_d.we.three = ok && (func == FUNC_THIRD);
    item_d.addr     = idx_ext[IDX_W-1:0];
    item_d.x        = s_axis_tdata[VI_W+VW-1:VI_W];
    item_d.v        = s_axis_tdata[VI_W+2*VW-1:VI_W+VW];
    item_d.a        = s_axis_tdata[VI_W+3*VW-1:VI_W+2*VW];
  end

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rk4u_fifo.sv
// ----------------------------------------------------------------------------
// rk4u_fifo
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4u_fifo import rk4u_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  item_t         mem_q [Q_DEPTH];
  logic [QP_W:0] wptr_q, wptr_d;
  logic [QP_W:0] rptr_q, rptr_d;

  assign full_o  = (wptr_q[QP_W] != rptr_q[QP_W]) &&
                   (wptr_q[QP_W-1:0] == rptr_q[QP_W-1:0]);
  assign empty_o = (wptr_q == rptr_q);
  assign item_o  = mem_q[rptr_q[QP_W-1:0]];

  assign wptr_d = wptr_q + (QP_W+1)'(push_i && !full_o);
  assign rptr_d = rptr_q + (QP_W+1)'(pop_i && !empty_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wptr_q[QP_W-1:0]] <= item_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rk4u_qmul.sv
// ----------------------------------------------------------------------------
// rk4u_qmul
// Two-stage fractional multiply: floor(a * f / 2^32) for a signed operand
// and an unsigned Q0.32 factor, split into two partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4u_qmul import rk4u_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [QW-1:0] a_i,
  input  logic        [FW-1:0] f_i,
  output logic signed [QW-1:0] p_o
);

  logic signed [QW-FW-1:0] hi;
  logic signed [FW:0]      f_s;
  logic signed [QW:0]      ph_d, ph_q;
  logic [2*FW-1:0]         pl_d;
  logic [FW-1:0]           pl_q;
  logic [QW:0]             sum;
  logic signed [QW-1:0]    p_q;

  assign hi   = a_i[QW-1:FW];
  assign f_s  = {1'b0, f_i};
  assign ph_d = hi * f_s;
  assign pl_d = a_i[FW-1:0] * f_i;
  assign sum  = ph_q + (QW+1)'({1'b0, pl_q});
  assign p_o  = p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q <= ph_d;
      pl_q <= pl_d[2*FW-1:FW];
      p_q  <= sum[QW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rk4u_back.sv
// ----------------------------------------------------------------------------
// rk4u_back
// Execution pipeline: increment multiply, per-variable store access with
// one-deep write bypass, stage arithmetic and saturation, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4u_back import rk4u_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 empty_i,
  input  item_t                item_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic [M_TUSER_W-1:0] m_axis_tuser
);

  localparam int NSTG = 10;

  typedef struct packed {
    logic [1:0]  func;
    logic [VW-1:0] x;
    logic [VW-1:0] v;
    logic [VW-1:0] x0;
    logic [VW-1:0] v0;
    logic [VW-1:0] k1;
    logic [VW:0]   s;
    logic [VW:0]   a1;
    logic [VW:0]   h2;
    logic [VW:0]   nve;
  } s4_t;

  typedef struct packed {
    logic [1:0]    func;
    logic [VW-1:0] x;
    logic [VW-1:0] x0;
    logic [VW-1:0] v0;
    logic [VW:0]   nve;
  } mid_t;

  typedef struct packed {
    logic [1:0]    func;
    logic [VW-1:0] x0;
    logic [QW-1:0] pacc;
    logic [QW-1:0] nv;
  } tail_t;

  logic              en;
  logic [NSTG-1:0]   vld_q, vld_d;
  logic              out_vld_q, out_vld_d;

  item_t             s1_q, s2_q, s3_q;
  logic signed [QW-1:0] kmul_p, mul1_p, mul2_p, mul3_p;
  logic signed [VW-1:0] k;

  logic [VW-1:0]     start_pos_mem  [NUM_VARS];
  logic [VW-1:0]     start_vel_mem  [NUM_VARS];
  logic [VW-1:0]     incr_one_mem   [NUM_VARS];
  logic [VW-1:0]     incr_two_mem   [NUM_VARS];
  logic [VW-1:0]     incr_three_mem [NUM_VARS];
  logic [VW-1:0]     rd_pos_q, rd_vel_q, rd_one_q, rd_two_q, rd_three_q;
  logic [VW-1:0]     byp_pos_q, byp_vel_q, byp_k_q;
  wr_t               byp_q, byp_d;
  logic              same_addr;

  logic signed [VW-1:0] x3, v3, x0, v0, k1, k2, k3;
  logic signed [VW+1:0] t;
  logic signed [VW+2:0] u;

  s4_t               s4_d, s4_q;
  mid_t              s5_d, s5_q, s6_q, s7_q;
  logic [QW-1:0]     op1_d, op1_q, u_d, u_q;
  logic [FW-1:0]     f1_d, f1_q;
  tail_t             s8_d, s8_q, s9_q, s10_q;

  logic signed [QW-1:0] np;
  sat_t              sat_p, sat_v;
  logic [VW-1:0]     out_pos_q, out_vel_q;
  logic              out_sat_q;

  assign en    = !out_vld_q || m_axis_tready;
  assign pop_o = en && !empty_i;

  assign vld_d     = {vld_q[NSTG-2:0], pop_o};
  assign out_vld_d = en ? vld_q[NSTG-1] : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
      byp_q     <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      if (en) begin
        vld_q <= vld_d;
        byp_q <= byp_d;
      end
    end
  end

  rk4u_qmul u_kmul (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (QW'($signed(s1_q.a))),
    .f_i   (cfg_i.full),
    .p_o   (kmul_p)
  );

  assign k = kmul_p[VW-1:0];

  assign same_addr     = vld_q[2] && (s3_q.addr == s2_q.addr);
  assign byp_d.start   = same_addr && s3_q.we.start;
  assign byp_d.two     = same_addr && s3_q.we.two;
  assign byp_d.three   = same_addr && s3_q.we.three;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (vld_q[2] && s3_q.we.start) begin
        start_pos_mem[s3_q.addr] <= s3_q.x;
        start_vel_mem[s3_q.addr] <= s3_q.v;
        incr_one_mem[s3_q.addr]  <= k;
      end
      if (vld_q[2] && s3_q.we.two) begin
        incr_two_mem[s3_q.addr] <= k;
      end
      if (vld_q[2] && s3_q.we.three) begin
        incr_three_mem[s3_q.addr] <= k;
      end
      rd_pos_q   <= start_pos_mem[s2_q.addr];
      rd_vel_q   <= start_vel_mem[s2_q.addr];
      rd_one_q   <= incr_one_mem[s2_q.addr];
      rd_two_q   <= incr_two_mem[s2_q.addr];
      rd_three_q <= incr_three_mem[s2_q.addr];
      byp_pos_q  <= s3_q.x;
      byp_vel_q  <= s3_q.v;
      byp_k_q    <= k;
    end
  end

  always_comb begin
    x3 = s3_q.x;
    v3 = s3_q.v;
    x0 = '0;
    v0 = '0;
    k1 = '0;
    k2 = '0;
    k3 = '0;
    if (s3_q.ok) begin
      x0 = byp_q.start ? byp_pos_q : rd_pos_q;
      v0 = byp_q.start ? byp_vel_q : rd_vel_q;
      k1 = byp_q.start ? byp_k_q : rd_one_q;
      k2 = byp_q.two ? byp_k_q : rd_two_q;
      k3 = byp_q.three ? byp_k_q : rd_three_q;
    end
  end

  always_comb begin
    s4_d.func = s3_q.func;
    s4_d.x    = x3;
    s4_d.v    = v3;
    s4_d.x0   = x0;
    s4_d.v0   = v0;
    s4_d.k1   = k1;
    s4_d.s    = (VW+1)'(k2) + (VW+1)'(k3);
    s4_d.a1   = (VW+1)'(k1) + (VW+1)'(k);
    s4_d.h2   = (VW+1)'(v0) + (VW+1)'(k2 >>> 1);
    case (s3_q.func)
      FUNC_FIRST:  s4_d.nve = (VW+1)'(v3) + (VW+1)'(k >>> 1);
      FUNC_SECOND: s4_d.nve = (VW+1)'(v0) + (VW+1)'(k >>> 1);
      FUNC_THIRD:  s4_d.nve = (VW+1)'(v0) + (VW+1)'(k);
      default:     s4_d.nve = '0;
    endcase
  end

  assign t = (VW+2)'($signed(s4_q.k1)) + (VW+2)'($signed(s4_q.s));
  assign u = (VW+3)'($signed(s4_q.a1)) + ((VW+3)'($signed(s4_q.s)) <<< 1);

  always_comb begin
    s5_d.func = s4_q.func;
    s5_d.x    = s4_q.x;
    s5_d.x0   = s4_q.x0;
    s5_d.v0   = s4_q.v0;
    s5_d.nve  = s4_q.nve;
    u_d       = QW'(u);
    case (s4_q.func)
      FUNC_FIRST: begin
        op1_d = QW'($signed(s4_q.v));
        f1_d  = cfg_i.half;
      end
      FUNC_SECOND: begin
        op1_d = QW'($signed(s4_q.k1));
        f1_d  = cfg_i.quarter;
      end
      FUNC_THIRD: begin
        op1_d = QW'($signed(s4_q.h2));
        f1_d  = cfg_i.full;
      end
      default: begin
        op1_d = QW'(t);
        f1_d  = SIXTH_Q32;
      end
    endcase
  end

  rk4u_qmul u_mul1 (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   ($signed(op1_q)),
    .f_i   (f1_q),
    .p_o   (mul1_p)
  );

  rk4u_qmul u_mul3 (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   ($signed(u_q)),
    .f_i   (SIXTH_Q32),
    .p_o   (mul3_p)
  );

  always_comb begin
    s8_d.func = s7_q.func;
    s8_d.x0   = s7_q.x0;
    s8_d.nv   = QW'($signed(s7_q.nve));
    case (s7_q.func)
      FUNC_FINAL: begin
        s8_d.pacc = QW'($signed(s7_q.v0)) + mul1_p;
        s8_d.nv   = QW'($signed(s7_q.v0)) + mul3_p;
      end
      FUNC_THIRD:  s8_d.pacc = QW'($signed(s7_q.x0)) + mul1_p;
      default:     s8_d.pacc = QW'($signed(s7_q.x)) + mul1_p;
    endcase
  end

  rk4u_qmul u_mul2 (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   ($signed(s8_q.pacc)),
    .f_i   (cfg_i.full),
    .p_o   (mul2_p)
  );

  assign np    = (s10_q.func == FUNC_FINAL) ? QW'($signed(s10_q.x0)) + mul2_p
                                             : $signed(s10_q.pacc);
  assign sat_p = sat48(np);
  assign sat_v = sat48($signed(s10_q.nv));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q      <= item_i;
      s2_q      <= s1_q;
      s3_q      <= s2_q;
      s4_q      <= s4_d;
      s5_q      <= s5_d;
      op1_q     <= op1_d;
      f1_q      <= f1_d;
      u_q       <= u_d;
      s6_q      <= s5_q;
      s7_q      <= s6_q;
      s8_q      <= s8_d;
      s9_q      <= s8_q;
      s10_q     <= s9_q;
      out_pos_q <= sat_p.value;
      out_vel_q <= sat_v.value;
      out_sat_q <= sat_p.clip || sat_v.clip;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_vel_q, out_pos_q};
  assign m_axis_tuser  = out_sat_q;

endmodule

`default_nettype wire

// File: hw/rtl/rk4_second_order_stage_update.sv
// ----------------------------------------------------------------------------
// rk4_second_order_stage_update
// Per-variable state update of a four-stage Runge-Kutta integrator for a
// second-order system, with step registers on an APB-style port.
//
//   channel   dir  handshake                 contents
//   s_axis    in   tvalid/tready             stage, index, pos, vel, acc
//   m_axis    out  tvalid/tready             new pos, new vel, clip flag
//   apb       in   psel/penable, pready = 1  step_full, step_half, step_quarter
//
// One word per cycle sustained while m_axis is ready; the store
// read-modify-write with a one-deep bypass sets that rate. An accepted
// word passes the front register, the queue, the execution pipeline and
// the output register before m_axis_tvalid. Stores have undefined contents after
// reset; no clearing pass. A stalled m_axis freezes the execution pipeline
// while the front register and a 4-entry queue keep taking up to 5 words.
`default_nettype none

module rk4_second_order_stage_update import rk4u_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // var_index[9:0], pos_in[57:10], vel_in[105:58], acc_in[153:106], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // func[1:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // pos_out[47:0], vel_out[95:48]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // saturated[0]
  output logic [M_TUSER_W-1:0] m_axis_tuser,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  cfg_t  cfg_q, cfg_d;
  logic  cfg_wr;
  logic  push, full, pop, empty;
  item_t push_item, pop_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[APB_AW-1:2])
        REG_STEP_FULL:    cfg_d.full    = pwdata;
        REG_STEP_HALF:    cfg_d.half    = pwdata;
        REG_STEP_QUARTER: cfg_d.quarter = pwdata;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[APB_AW-1:2])
      REG_STEP_FULL:    prdata = cfg_q.full;
      REG_STEP_HALF:    prdata = cfg_q.half;
      REG_STEP_QUARTER: prdata = cfg_q.quarter;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rk4u_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .item_o        (push_item)
  );

  rk4u_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (pop_item)
  );

  rk4u_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .empty_i       (empty),
    .item_i        (pop_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// File: hw/rtl/rk4u_checker.sv
// ----------------------------------------------------------------------------
// rk4u_checker
// Port-level checks: output hold under stall, clip flag against the
// saturation limits, and word accounting between input and output.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4u_checker import rk4u_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [M_TUSER_W-1:0] m_axis_tuser
);

  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [5:0]    CAP  = 6'd16;

  logic          in_acc, out_acc;
  logic [5:0]    cnt_q, cnt_d;
  logic [VW-1:0] pos, vel;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign pos     = m_axis_tdata[VW-1:0];
  assign vel     = m_axis_tdata[2*VW-1:VW];

  always_comb begin
    case ({in_acc, out_acc})
      2'b10:   cnt_d = cnt_q + 6'd1;
      2'b01:   cnt_d = cnt_q - 6'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed under stall");

  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (pos == VMAX || pos == VMIN || vel == VMAX || vel == VMIN))
    else $error("clip flag without a saturated value");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != 6'd0)
    else $error("output word with no input word outstanding");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CAP)
    else $error("more words outstanding than the pipeline holds");

endmodule

bind rk4_second_order_stage_update rk4u_checker u_rk4u_checker (.*);

`default_nettype wire
